/* design/afl_pkg.sv */
`timescale 1ns / 1ps

package afl_pkg;

    localparam int DIM_BITS   = 13;
    localparam int POS_BITS   = DIM_BITS + 1;
    localparam int OUT_BITS   = DIM_BITS + 2;
    localparam int PROD_BITS  = 2 * DIM_BITS;
    localparam int DIV_STAGES = DIM_BITS;

    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_COPY,
        MODE_EQUAL,
        MODE_LETTER,
        MODE_PILLAR
    } afl_mode_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] dx;
        logic signed [POS_BITS-1:0] dy;
        logic [DIM_BITS-1:0]        dw;
        logic [DIM_BITS-1:0]        dh;
        logic [DIM_BITS-1:0]        sw;
        logic [DIM_BITS-1:0]        sh;
    } afl_geom_t;

    typedef struct packed {
        afl_mode_t mode;
        afl_geom_t geom;
    } afl_ctx_t;

endpackage

/* design/afl_ifs.sv */
`timescale 1ns / 1ps

interface afl_req_if import afl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [DIM_BITS-1:0]        video_w;
    logic [DIM_BITS-1:0]        video_h;
    logic signed [POS_BITS-1:0] render_x;
    logic signed [POS_BITS-1:0] render_y;
    logic [DIM_BITS-1:0]        render_w;
    logic [DIM_BITS-1:0]        render_h;
    logic signed [POS_BITS-1:0] win_x;
    logic signed [POS_BITS-1:0] win_y;
    logic [DIM_BITS-1:0]        win_w;
    logic [DIM_BITS-1:0]        win_h;

    modport source (
        output valid, video_w, video_h, render_x, render_y, render_w, render_h,
               win_x, win_y, win_w, win_h,
        input  ready
    );
    modport sink (
        input  valid, video_w, video_h, render_x, render_y, render_w, render_h,
               win_x, win_y, win_w, win_h,
        output ready
    );
endinterface

interface afl_rsp_if import afl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] out_x;
    logic signed [OUT_BITS-1:0] out_y;
    logic [DIM_BITS-1:0]        out_w;
    logic [DIM_BITS-1:0]        out_h;
    logic                       invalid;

    modport source (
        output valid, out_x, out_y, out_w, out_h, invalid,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_w, out_h, invalid,
        output ready
    );
endinterface

interface afl_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* design/afl_front.sv */
`timescale 1ns / 1ps

module afl_front import afl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 scale_en,
    afl_req_if.sink              req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output afl_ctx_t             out_ctx,
    output logic [PROD_BITS-1:0] out_num,
    output logic [DIM_BITS-1:0]  out_den
);

    logic                 a_valid_reg;
    afl_geom_t            a_geom_reg;
    afl_geom_t            a_geom_next;
    logic                 a_zero_reg;
    logic                 a_zero_next;
    logic                 a_scale_reg;
    logic [PROD_BITS-1:0] a_lhs_reg;
    logic [PROD_BITS-1:0] a_lhs_next;
    logic [PROD_BITS-1:0] a_rhs_reg;
    logic [PROD_BITS-1:0] a_rhs_next;
    logic                 a_ready;

    logic                 b_valid_reg;
    afl_ctx_t             b_ctx_reg;
    afl_ctx_t             b_ctx_next;
    logic [PROD_BITS-1:0] b_num_reg;
    logic [PROD_BITS-1:0] b_num_next;
    logic [DIM_BITS-1:0]  b_den_reg;
    logic [DIM_BITS-1:0]  b_den_next;
    logic                 b_ready;

    logic win_set;
    logic use_render;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req.ready = a_ready;

    // The window wins when set, unless it covers the render area on both axes.
    always_comb
    begin
        win_set    = (req.win_w != '0) && (req.win_h != '0);
        use_render = win_set && (req.win_w > req.render_w) && (req.win_h > req.render_h);
        a_geom_next.sw = req.video_w;
        a_geom_next.sh = req.video_h;
        if (!win_set)
        begin
            a_geom_next.dx = '0;
            a_geom_next.dy = '0;
            a_geom_next.dw = req.render_w;
            a_geom_next.dh = req.render_h;
        end
        else if (use_render)
        begin
            a_geom_next.dx = req.render_x;
            a_geom_next.dy = req.render_y;
            a_geom_next.dw = req.render_w;
            a_geom_next.dh = req.render_h;
        end
        else
        begin
            a_geom_next.dx = req.win_x;
            a_geom_next.dy = req.win_y;
            a_geom_next.dw = req.win_w;
            a_geom_next.dh = req.win_h;
        end
        a_zero_next = (req.video_w == '0) || (req.video_h == '0) ||
                      (a_geom_next.dw == '0) || (a_geom_next.dh == '0);
        a_lhs_next  = PROD_BITS'(req.video_w) * PROD_BITS'(a_geom_next.dh);
        a_rhs_next  = PROD_BITS'(a_geom_next.dw) * PROD_BITS'(req.video_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && req.valid)
        begin
            a_geom_reg  <= a_geom_next;
            a_zero_reg  <= a_zero_next;
            a_scale_reg <= scale_en;
            a_lhs_reg   <= a_lhs_next;
            a_rhs_reg   <= a_rhs_next;
        end
    end

    always_comb
    begin
        b_ctx_next.geom = a_geom_reg;
        b_num_next      = a_lhs_reg;
        b_den_next      = a_geom_reg.sh;
        if (a_zero_reg)
        begin
            b_ctx_next.mode = MODE_ZERO;
        end
        else if (!a_scale_reg)
        begin
            b_ctx_next.mode = MODE_COPY;
        end
        else if (a_lhs_reg > a_rhs_reg)
        begin
            b_ctx_next.mode = MODE_LETTER;
            b_num_next      = a_rhs_reg;
            b_den_next      = a_geom_reg.sw;
        end
        else if (a_lhs_reg < a_rhs_reg)
        begin
            b_ctx_next.mode = MODE_PILLAR;
        end
        else
        begin
            b_ctx_next.mode = MODE_EQUAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_ctx_reg <= b_ctx_next;
            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ctx   = b_ctx_reg;
    assign out_num   = b_num_reg;
    assign out_den   = b_den_reg;

endmodule

/* design/afl_div.sv */
`timescale 1ns / 1ps

module afl_div import afl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  afl_ctx_t             in_ctx,
    input  logic [PROD_BITS-1:0] in_num,
    input  logic [DIM_BITS-1:0]  in_den,
    output logic                 out_valid,
    input  logic                 out_ready,
    output afl_ctx_t             out_ctx,
    output logic [DIM_BITS-1:0]  out_quo
);

    logic                 valid_reg [DIV_STAGES];
    logic [PROD_BITS-1:0] rem_reg   [DIV_STAGES];
    logic [DIM_BITS-1:0]  den_reg   [DIV_STAGES];
    logic [DIM_BITS-1:0]  quo_reg   [DIV_STAGES];
    afl_ctx_t             ctx_reg   [DIV_STAGES];
    logic [DIV_STAGES:0]  stage_ready;
    wire  [DIV_STAGES-1:0] valid_vec;

    assign stage_ready[DIV_STAGES] = out_ready;

    genvar i;
    for (i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        localparam int SHIFT = DIV_STAGES - 1 - i;

        logic                 valid_in;
        logic [PROD_BITS-1:0] rem_in;
        logic [DIM_BITS-1:0]  den_in;
        logic [DIM_BITS-1:0]  quo_in;
        afl_ctx_t             ctx_in;
        logic [PROD_BITS-1:0] trial;
        logic                 take;
        logic [PROD_BITS-1:0] rem_next;
        logic [DIM_BITS-1:0]  quo_next;

        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_num;
            assign den_in   = in_den;
            assign quo_in   = '0;
            assign ctx_in   = in_ctx;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign ctx_in   = ctx_reg[i-1];
        end

        assign trial          = PROD_BITS'(den_in) << SHIFT;
        assign take           = rem_in >= trial;
        assign rem_next       = take ? rem_in - trial : rem_in;
        assign quo_next       = take ? quo_in | (DIM_BITS'(1) << SHIFT) : quo_in;
        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        assign valid_vec[i]   = valid_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_ready[i])
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i] && valid_in)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
                ctx_reg[i] <= ctx_in;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_ctx   = ctx_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $countones(valid_vec) == DIV_STAGES)
        else $error("Divider refused a beat while holding a bubble.");

    a_letter_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ctx.mode == MODE_LETTER |-> out_quo < out_ctx.geom.dh)
        else $error("Letterbox height exceeds the destination height.");

    a_pillar_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ctx.mode == MODE_PILLAR |-> out_quo < out_ctx.geom.dw)
        else $error("Pillarbox width exceeds the destination width.");

endmodule

/* design/afl_back.sv */
`timescale 1ns / 1ps

module afl_back import afl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  afl_ctx_t            in_ctx,
    input  logic [DIM_BITS-1:0] in_quo,
    afl_rsp_if.source           rsp
);

    logic                       valid_reg;
    logic signed [OUT_BITS-1:0] x_reg;
    logic signed [OUT_BITS-1:0] x_next;
    logic signed [OUT_BITS-1:0] y_reg;
    logic signed [OUT_BITS-1:0] y_next;
    logic [DIM_BITS-1:0]        w_reg;
    logic [DIM_BITS-1:0]        w_next;
    logic [DIM_BITS-1:0]        h_reg;
    logic [DIM_BITS-1:0]        h_next;
    logic                       invalid_reg;
    logic                       invalid_next;
    logic [DIM_BITS-1:0]        spare_w;
    logic [DIM_BITS-1:0]        spare_h;
    afl_geom_t                  g;

    assign g        = in_ctx.geom;
    assign in_ready = !valid_reg || rsp.ready;

    // The placed size is picked first; centering then uses half the spare room on each axis.
    always_comb
    begin
        w_next       = g.dw;
        h_next       = g.dh;
        invalid_next = 1'b0;
        case (in_ctx.mode)
            MODE_ZERO:
            begin
                invalid_next = 1'b1;
            end
            MODE_COPY:
            begin
                w_next = (g.sw < g.dw) ? g.sw : g.dw;
                h_next = (g.sh < g.dh) ? g.sh : g.dh;
            end
            MODE_LETTER:
            begin
                h_next = in_quo;
            end
            MODE_PILLAR:
            begin
                w_next = in_quo;
            end
            default:
            begin
                w_next = g.dw;
            end
        endcase
        spare_w = g.dw - w_next;
        spare_h = g.dh - h_next;
        x_next  = {g.dx[POS_BITS-1], g.dx} + {2'b00, spare_w >> 1};
        y_next  = {g.dy[POS_BITS-1], g.dy} + {2'b00, spare_h >> 1};
        if (invalid_next)
        begin
            w_next = '0;
            h_next = '0;
            x_next = '0;
            y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            invalid_reg <= invalid_next;
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.out_x   = x_reg;
    assign rsp.out_y   = y_reg;
    assign rsp.out_w   = w_reg;
    assign rsp.out_h   = h_reg;
    assign rsp.invalid = invalid_reg;

endmodule

/* design/aspect_fit_letterbox_rect_unit.sv */
`timescale 1ns / 1ps
// Channel  Role    Beat contents
// req      sink    frame size, render rectangle, window rectangle
// rsp      source  placed rectangle and invalid flag
// cfg      sink    scale enable bit
//
// One rectangle is accepted per cycle while the output is not stalled. The restoring
// divider resolves one quotient bit per stage.
// Every stage loads on its own ready, so bubbles close up while the output is stalled.
// Reset clears all stage valid bits and sets scale enable to 1.
// A configuration write takes effect for rectangles accepted after it.

module aspect_fit_letterbox_rect_unit import afl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    afl_req_if.sink    req,
    afl_rsp_if.source  rsp,
    afl_cfg_if.sink    cfg
);

    logic                 scale_en_reg;
    logic                 fr_valid;
    logic                 fr_ready;
    afl_ctx_t             fr_ctx;
    logic [PROD_BITS-1:0] fr_num;
    logic [DIM_BITS-1:0]  fr_den;
    logic                 dv_valid;
    logic                 dv_ready;
    afl_ctx_t             dv_ctx;
    logic [DIM_BITS-1:0]  dv_quo;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            scale_en_reg <= cfg.data;
        end
    end

    afl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale_en  (scale_en_reg),
        .req       (req),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_ctx   (fr_ctx),
        .out_num   (fr_num),
        .out_den   (fr_den)
    );

    afl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_ctx    (fr_ctx),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_ctx   (dv_ctx),
        .out_quo   (dv_quo)
    );

    afl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .in_ready (dv_ready),
        .in_ctx   (dv_ctx),
        .in_quo   (dv_quo),
        .rsp      (rsp)
    );

endmodule
